>>> rtl/core/dnsd_pkg.sv
// dnsd_pkg: constants, codes and types for the DNS name decompressor.
// No dependencies.
`timescale 1ns / 1ps
package dnsd_pkg;
  localparam int PacketBytes = 4096;
  localparam int PktAw       = $clog2(PacketBytes);
  localparam int MaxJumps    = 100;
  localparam int JmpAw       = $clog2(MaxJumps);
  localparam int NameLimit   = 253;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_DECODE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISSING   = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_TRUNC_PTR = 3'd3,
    ST_BAD_PTR   = 3'd4,
    ST_BAD_LABEL = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [13:0] position;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] next_offset;
    logic [7:0]  name_length;
    logic [7:0]  name_char;
  } result_t;

  // Lowercase A-Z only.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction
endpackage

>>> rtl/core/dnsd_stream_if.sv
// dnsd_stream_if: valid/ready channel carrying one payload type.
// Depends on dnsd_pkg.
`timescale 1ns / 1ps
interface dnsd_item_if;
  logic            valid;
  logic            ready;
  dnsd_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/dnsd_result_if.sv
// dnsd_result_if: valid/ready channel for result items.
// Depends on dnsd_pkg.
`timescale 1ns / 1ps
interface dnsd_result_if;
  logic              valid;
  logic              ready;
  dnsd_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/dns_name_decompressor_top.sv
// dns_name_decompressor_top: packet store, name walker and name buffer.
// Depends on dnsd_pkg, dnsd_item_if, dnsd_result_if.
//
//  channel | dir | payload
//  in_i    | in  | kind, data_byte, first_byte, position
//  out_o   | out | status, next_offset, name_length, name_char
//
// Load: 1 cycle. Read: result valid 2 cycles after the transfer. Decode: one
// cycle per label byte and name character walked, three per pointer plus two
// per target already on the visited list, then two per trailing dot stripped,
// two per name character lowercased and one for the final dot; set by the
// single-port memories and the serial visited-list search.
// Reset clears control only; no clearing pass. A stalled output holds
// the block; a new item is taken once the result register is free.
`timescale 1ns / 1ps
module dns_name_decompressor_top (
  input  logic clk_i,
  input  logic rst_ni,
  dnsd_item_if.sink     in_i,
  dnsd_result_if.source out_o
);
  localparam int Aw = dnsd_pkg::PktAw;
  localparam int Jw = dnsd_pkg::JmpAw;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_LABEL = 11'b00000000010, // wait for label byte
    S_PTR   = 11'b00000000100, // wait for second pointer byte
    S_SCAN  = 11'b00000001000, // visited list read issued
    S_SCHK  = 11'b00000010000, // compare visited entry
    S_COPY  = 11'b00000100000, // label char read
    S_TRIM  = 11'b00001000000, // read last raw char
    S_TCHK  = 11'b00010000000,
    S_NORM  = 11'b00100000000, // lowercase pass
    S_NWR   = 11'b01000000000,
    S_READ  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [Aw:0]   plen_q, plen_d;
  logic [14:0]   cur_q, cur_d;      // cursor
  logic [14:0]   nxt_q, nxt_d;
  logic          jumped_q, jumped_d;
  logic [6:0]    jcnt_q, jcnt_d;
  logic [6:0]    sidx_q, sidx_d;
  logic [13:0]   cur_tgt_q, cur_tgt_d;
  logic [7:0]    raw_q, raw_d;      // raw name length
  logic [5:0]    lrem_q, lrem_d;    // label chars left
  logic [5:0]    hi_q, hi_d;        // pointer high bits
  logic [7:0]    slen_q, slen_d;
  logic [7:0]    ni_q, ni_d;        // normalize index
  logic [13:0]   rpos_q, rpos_d;
  logic          ovld_q, ovld_d;
  dnsd_pkg::result_t ores_q, ores_d;

  // memories
  logic [7:0]  pkt_mem [dnsd_pkg::PacketBytes];
  logic [13:0] vis_mem [dnsd_pkg::MaxJumps];
  logic [7:0]  name_mem [256];
  logic [7:0]  pkt_rd_q, name_rd_q;
  logic [13:0] vis_rd_q;

  logic          pkt_we, name_we, vis_we;
  logic [Aw-1:0] pkt_wa, pkt_ra;
  logic [7:0]    pkt_wd, name_wa, name_ra, name_wd;
  logic [Jw-1:0] vis_a, vis_ra;

  always_ff @(posedge clk_i) begin
    if (pkt_we) pkt_mem[pkt_wa] <= pkt_wd;
    pkt_rd_q <= pkt_mem[pkt_ra];
  end
  always_ff @(posedge clk_i) begin
    if (name_we) name_mem[name_wa] <= name_wd;
    name_rd_q <= name_mem[name_ra];
  end
  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_a] <= cur_tgt_q;
    vis_rd_q <= vis_mem[vis_ra];
  end

  assign in_i.ready = (state_q == S_IDLE) && !ovld_q;
  assign out_o.valid = ovld_q;
  assign out_o.data  = ores_q;

  wire acc = in_i.valid && in_i.ready;
  wire [14:0] plen15 = 15'(plen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plen_q <= '0; slen_q <= '0; ovld_q <= 1'b0; jcnt_q <= '0;
    end else begin
      state_q <= state_d;
      plen_q <= plen_d; slen_q <= slen_d; ovld_q <= ovld_d; jcnt_q <= jcnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; nxt_q <= nxt_d; jumped_q <= jumped_d; sidx_q <= sidx_d;
    cur_tgt_q <= cur_tgt_d; raw_q <= raw_d; lrem_q <= lrem_d; hi_q <= hi_d;
    ni_q <= ni_d; rpos_q <= rpos_d; ores_q <= ores_d;
  end

  // walker control
  always_comb begin
    logic [7:0]  lab;
    logic [13:0] tgt;
    logic [8:0]  need;
    state_d = state_q; plen_d = plen_q; cur_d = cur_q; nxt_d = nxt_q;
    jumped_d = jumped_q; jcnt_d = jcnt_q; sidx_d = sidx_q; cur_tgt_d = cur_tgt_q;
    raw_d = raw_q; lrem_d = lrem_q; hi_d = hi_q; slen_d = slen_q; ni_d = ni_q;
    rpos_d = rpos_q; ovld_d = ovld_q; ores_d = ores_q;
    pkt_we = 1'b0; pkt_wa = plen_q[Aw-1:0]; pkt_wd = in_i.data.data_byte;
    pkt_ra = cur_q[Aw-1:0];
    name_we = 1'b0; name_wa = raw_q; name_wd = pkt_rd_q; name_ra = ni_q;
    vis_we = 1'b0; vis_a = Jw'(jcnt_q - 7'd1); vis_ra = sidx_q[Jw-1:0];
    lab = pkt_rd_q;
    tgt = {hi_q, pkt_rd_q};
    need = 9'(raw_q) + 9'(lab) + ((raw_q == 8'd0) ? 9'd0 : 9'd1);
    if (out_o.valid && out_o.ready) ovld_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (acc) begin
        case (in_i.data.kind)
          dnsd_pkg::KIND_LOAD: begin
            if (in_i.data.first_byte) begin
              pkt_wa = '0; pkt_we = 1'b1; plen_d = (Aw+1)'(1);
            end else if (plen_q < (Aw+1)'(dnsd_pkg::PacketBytes)) begin
              pkt_we = 1'b1; plen_d = plen_q + 1'b1;
            end
          end
          dnsd_pkg::KIND_DECODE: begin
            nxt_d = 15'(in_i.data.position); cur_d = 15'(in_i.data.position);
            slen_d = '0; jcnt_d = '0; jumped_d = 1'b0; raw_d = '0;
            pkt_ra = in_i.data.position[Aw-1:0];
            if (15'(in_i.data.position) >= plen15) begin
              ores_d = '{dnsd_pkg::ST_MISSING, 15'(in_i.data.position), 8'd0, 8'd0};
              ovld_d = 1'b1;
            end else state_d = S_LABEL;
          end
          dnsd_pkg::KIND_READ: begin
            rpos_d = in_i.data.position; name_ra = in_i.data.position[7:0];
            state_d = S_READ;
          end
          default: ;
        endcase
      end
      S_READ: begin
        ores_d = '{dnsd_pkg::ST_OK, 15'd0, slen_q,
                   (rpos_q < 14'(slen_q)) ? name_rd_q : 8'd0};
        ovld_d = 1'b1; state_d = S_IDLE;
      end
      S_LABEL: begin
        if (lab == 8'd0) begin
          if (!jumped_q) nxt_d = cur_q + 15'd1;
          ni_d = raw_q; state_d = S_TRIM;
          name_ra = raw_q - 8'd1;
          if (raw_q == 8'd0) state_d = S_NORM;
          ni_d = 8'd0;
        end else if (lab[7:6] == 2'b11) begin
          if (cur_q + 15'd1 >= plen15) begin
            ores_d = '{dnsd_pkg::ST_TRUNC_PTR, nxt_q, 8'd0, 8'd0};
            ovld_d = 1'b1; state_d = S_IDLE;
          end else begin
            hi_d = lab[5:0]; pkt_ra = Aw'(cur_q + 15'd1); state_d = S_PTR;
          end
        end else if (lab[7:6] != 2'b00 || 15'(cur_q) + 15'd1 + 15'(lab) > plen15) begin
          ores_d = '{dnsd_pkg::ST_BAD_LABEL, nxt_q, 8'd0, 8'd0};
          ovld_d = 1'b1; state_d = S_IDLE;
        end else if (need > 9'(dnsd_pkg::NameLimit)) begin
          ores_d = '{dnsd_pkg::ST_TOO_LONG, nxt_q, 8'd0, 8'd0};
          ovld_d = 1'b1; state_d = S_IDLE;
        end else begin
          if (raw_q != 8'd0) begin
            name_we = 1'b1; name_wd = 8'h2e; raw_d = raw_q + 8'd1;
          end
          lrem_d = lab[5:0]; cur_d = cur_q + 15'd1;
          pkt_ra = Aw'(cur_q + 15'd1); state_d = S_COPY;
        end
      end
      S_COPY: begin
        // pkt_rd_q holds char at cur_q
        name_we = 1'b1; name_wd = pkt_rd_q; raw_d = raw_q + 8'd1;
        cur_d = cur_q + 15'd1; lrem_d = lrem_q - 6'd1;
        pkt_ra = Aw'(cur_q + 15'd1);
        if (lrem_q == 6'd1) begin
          if (cur_q + 15'd1 >= plen15) begin
            ores_d = '{dnsd_pkg::ST_TRUNC, nxt_q, 8'd0, 8'd0};
            ovld_d = 1'b1; state_d = S_IDLE;
          end else state_d = S_LABEL;
        end
      end
      S_PTR: begin
        cur_tgt_d = tgt;
        // rejected before this pointer can move the next offset
        if (15'(tgt) >= plen15 || jcnt_q >= 7'(dnsd_pkg::MaxJumps)) begin
          ores_d = '{dnsd_pkg::ST_BAD_PTR, nxt_q, 8'd0, 8'd0};
          ovld_d = 1'b1; state_d = S_IDLE;
        end else begin
          if (!jumped_q) begin nxt_d = cur_q + 15'd2; jumped_d = 1'b1; end
          jcnt_d = jcnt_q + 7'd1; sidx_d = '0; state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sidx_q + 7'd1 >= jcnt_q) begin
          vis_we = 1'b1; cur_d = 15'(cur_tgt_q);
          pkt_ra = cur_tgt_q[Aw-1:0]; state_d = S_LABEL;
        end else state_d = S_SCHK;
      end
      S_SCHK: begin
        if (vis_rd_q == cur_tgt_q) begin
          ores_d = '{dnsd_pkg::ST_BAD_PTR, nxt_q, 8'd0, 8'd0};
          ovld_d = 1'b1; state_d = S_IDLE;
        end else begin
          sidx_d = sidx_q + 7'd1; vis_ra = Jw'(sidx_q + 7'd1); state_d = S_SCAN;
        end
      end
      S_TRIM: begin
        // hold the read on the last raw char for the check
        name_ra = raw_q - 8'd1; state_d = S_TCHK;
      end
      S_TCHK: begin
        if (name_rd_q == 8'h2e) begin
          raw_d = raw_q - 8'd1; name_ra = raw_q - 8'd2;
          state_d = (raw_q == 8'd1) ? S_NORM : S_TRIM;
        end else state_d = S_NORM;
      end
      S_NORM: begin
        if (ni_q == raw_q) begin
          name_we = 1'b1; name_wa = raw_q; name_wd = 8'h2e;
          slen_d = raw_q + 8'd1;
          ores_d = '{dnsd_pkg::ST_OK, nxt_q, raw_q + 8'd1, 8'd0};
          ovld_d = 1'b1; state_d = S_IDLE;
        end else state_d = S_NWR;
      end
      S_NWR: begin
        name_we = 1'b1; name_wa = ni_q; name_wd = dnsd_pkg::to_lower(name_rd_q);
        ni_d = ni_q + 8'd1; name_ra = ni_q + 8'd1; state_d = S_NORM;
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready) else $error("ready while busy");
  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= (Aw+1)'(dnsd_pkg::PacketBytes)) else $error("length overflow");
  a_jumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jcnt_q <= 7'(dnsd_pkg::MaxJumps)) else $error("jump count overflow");
`endif
endmodule
